// ===== hdl/homography_inlier_test_macros.svh =====
// ----------------------------------------------------------------------------
// Homography inlier test assertion macros
// Shared concurrent assertion forms for the homography inlier test checker.
// ----------------------------------------------------------------------------
`ifndef HOMOGRAPHY_INLIER_TEST_MACROS_SVH
`define HOMOGRAPHY_INLIER_TEST_MACROS_SVH

// The consequent must hold whenever the antecedent holds, outside reset.
`define HIT_ASSERT_IMP(label, ck, rst_n, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The condition must never be seen, outside reset.
`define HIT_ASSERT_NEVER(label, ck, rst_n, bad, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) !(bad)) \
		else $error(msg);

`endif

// ===== hdl/hit_pkg.sv =====
// ----------------------------------------------------------------------------
// Homography inlier test package
// Widths, register codes, reset values and payload types shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package hit_pkg;

	localparam int COORD_WIDTH = 24;
	localparam int IDX_W = 24;
	localparam int COEF_W = 32;
	localparam int TOL_W = 16;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W = 3;

	localparam int U_SHIFT = 20;
	localparam int W_SHIFT = 8;
	localparam int ERR_SHIFT = 8;

	localparam int PW = COEF_W + COORD_WIDTH;
	localparam int U_CONST_W = COEF_W + U_SHIFT;
	localparam int UW = ((PW > U_CONST_W) ? PW : U_CONST_W) + 2;
	localparam int WL = UW / 2;
	localparam int WH = UW - WL;
	localparam int EW = COORD_WIDTH + UW + 1;
	localparam int TW = TOL_W + 1 + UW;
	localparam int LW = 2 * EW + 1;

	localparam int PIPE_DEPTH = 9;
	localparam int DEG_DEPTH = PIPE_DEPTH - 2;

	localparam logic [CFG_IDX_W-1:0] REG_ROW0_AB = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_H02_H10 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_H11_H12 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_H20_H21 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_H22 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TOL = 3'd5;

	localparam logic [CFG_DATA_W-1:0] RST_ROW0_AB = 64'h0100_0000_0000_0000;
	localparam logic [CFG_DATA_W-1:0] RST_H02_H10 = 64'h0;
	localparam logic [CFG_DATA_W-1:0] RST_H11_H12 = 64'h0100_0000_0000_0000;
	localparam logic [CFG_DATA_W-1:0] RST_H20_H21 = 64'h0;
	localparam logic [COEF_W-1:0] RST_H22 = 32'h0100_0000;
	localparam logic [TOL_W-1:0] RST_TOL = 16'h0100;

	typedef struct packed {
		logic [IDX_W-1:0] match_index;
		logic signed [COORD_WIDTH-1:0] src_x;
		logic signed [COORD_WIDTH-1:0] src_y;
		logic signed [COORD_WIDTH-1:0] dst_x;
		logic signed [COORD_WIDTH-1:0] dst_y;
	} hit_req_t;

	typedef struct packed {
		logic [IDX_W-1:0] match_index_out;
		logic is_inlier;
		logic degenerate;
	} hit_result_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] h00;
		logic signed [COEF_W-1:0] h01;
		logic signed [COEF_W-1:0] h02;
		logic signed [COEF_W-1:0] h10;
		logic signed [COEF_W-1:0] h11;
		logic signed [COEF_W-1:0] h12;
		logic signed [COEF_W-1:0] h20;
		logic signed [COEF_W-1:0] h21;
		logic signed [COEF_W-1:0] h22;
	} hit_coef_t;

endpackage

`default_nettype wire

// ===== hdl/hit_proj.sv =====
// ----------------------------------------------------------------------------
// Homography projection stages
// Maps the source point through the matrix, giving u, v and w after two stages.
// ----------------------------------------------------------------------------
`default_nettype none

module hit_proj (
	input wire logic clk,
	input wire hit_pkg::hit_coef_t coef,
	input wire logic signed [hit_pkg::COORD_WIDTH-1:0] src_x,
	input wire logic signed [hit_pkg::COORD_WIDTH-1:0] src_y,
	input wire logic signed [hit_pkg::COORD_WIDTH-1:0] dst_x,
	input wire logic signed [hit_pkg::COORD_WIDTH-1:0] dst_y,
	output logic signed [hit_pkg::UW-1:0] u_s2,
	output logic signed [hit_pkg::UW-1:0] v_s2,
	output logic signed [hit_pkg::UW-1:0] w_s2,
	output logic signed [hit_pkg::COORD_WIDTH-1:0] dx_s2,
	output logic signed [hit_pkg::COORD_WIDTH-1:0] dy_s2
);

	localparam int PW = hit_pkg::PW;
	localparam int UW = hit_pkg::UW;

	logic signed [PW-1:0] pux_s1;
	logic signed [PW-1:0] puy_s1;
	logic signed [PW-1:0] pvx_s1;
	logic signed [PW-1:0] pvy_s1;
	logic signed [PW-1:0] pwx_s1;
	logic signed [PW-1:0] pwy_s1;
	logic signed [hit_pkg::COORD_WIDTH-1:0] dx_s1;
	logic signed [hit_pkg::COORD_WIDTH-1:0] dy_s1;

	always_ff @(posedge clk) begin
		pux_s1 <= coef.h00 * src_x;
		puy_s1 <= coef.h01 * src_y;
		pvx_s1 <= coef.h10 * src_x;
		pvy_s1 <= coef.h11 * src_y;
		pwx_s1 <= coef.h20 * src_x;
		pwy_s1 <= coef.h21 * src_y;
		dx_s1 <= dst_x;
		dy_s1 <= dst_y;
	end

	always_ff @(posedge clk) begin
		u_s2 <= UW'(pux_s1) + UW'(puy_s1) + (UW'(coef.h02) <<< hit_pkg::U_SHIFT);
		v_s2 <= UW'(pvx_s1) + UW'(pvy_s1) + (UW'(coef.h12) <<< hit_pkg::U_SHIFT);
		w_s2 <= UW'(pwx_s1) + UW'(pwy_s1) + (UW'(coef.h22) <<< hit_pkg::W_SHIFT);
		dx_s2 <= dx_s1;
		dy_s2 <= dy_s1;
	end

endmodule

`default_nettype wire

// ===== hdl/hit_err.sv =====
// ----------------------------------------------------------------------------
// Homography error stages
// Forms the scaled errors dst*w - (u <<< ERR_SHIFT) and the scaled tolerance tol*w.
// ----------------------------------------------------------------------------
`default_nettype none

module hit_err (
	input wire logic clk,
	input wire logic [hit_pkg::TOL_W-1:0] tol,
	input wire logic signed [hit_pkg::UW-1:0] u_s2,
	input wire logic signed [hit_pkg::UW-1:0] v_s2,
	input wire logic signed [hit_pkg::UW-1:0] w_s2,
	input wire logic signed [hit_pkg::COORD_WIDTH-1:0] dx_s2,
	input wire logic signed [hit_pkg::COORD_WIDTH-1:0] dy_s2,
	output logic signed [hit_pkg::EW-1:0] ex_s4,
	output logic signed [hit_pkg::EW-1:0] ey_s4,
	output logic signed [hit_pkg::TW-1:0] t_s4
);

	localparam int CW = hit_pkg::COORD_WIDTH;
	localparam int UW = hit_pkg::UW;
	localparam int WL = hit_pkg::WL;
	localparam int WH = hit_pkg::WH;
	localparam int EW = hit_pkg::EW;
	localparam int TW = hit_pkg::TW;
	localparam int TOL_W = hit_pkg::TOL_W;

	logic signed [WL:0] w_lo;
	logic signed [WH-1:0] w_hi;
	logic signed [TOL_W:0] tol_sx;

	logic signed [CW+WL:0] pxl_s3;
	logic signed [CW+WH-1:0] pxh_s3;
	logic signed [CW+WL:0] pyl_s3;
	logic signed [CW+WH-1:0] pyh_s3;
	logic signed [TOL_W+WL+1:0] tl_s3;
	logic signed [TOL_W+WH:0] th_s3;
	logic signed [UW-1:0] u_s3;
	logic signed [UW-1:0] v_s3;

	assign w_lo = $signed({1'b0, w_s2[WL-1:0]});
	assign w_hi = $signed(w_s2[UW-1:WL]);
	assign tol_sx = $signed({1'b0, tol});

	always_ff @(posedge clk) begin
		pxl_s3 <= dx_s2 * w_lo;
		pxh_s3 <= dx_s2 * w_hi;
		pyl_s3 <= dy_s2 * w_lo;
		pyh_s3 <= dy_s2 * w_hi;
		tl_s3 <= tol_sx * w_lo;
		th_s3 <= tol_sx * w_hi;
		u_s3 <= u_s2;
		v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		ex_s4 <= (EW'(pxh_s3) <<< WL) + EW'(pxl_s3) - (EW'(u_s3) <<< hit_pkg::ERR_SHIFT);
		ey_s4 <= (EW'(pyh_s3) <<< WL) + EW'(pyl_s3) - (EW'(v_s3) <<< hit_pkg::ERR_SHIFT);
		t_s4 <= (TW'(th_s3) <<< WL) + TW'(tl_s3);
	end

endmodule

`default_nettype wire

// ===== hdl/hit_sqr.sv =====
// ----------------------------------------------------------------------------
// Homography wide squarer
// Squares a wide signed value over three stages from three-chunk partial
// products.
// ----------------------------------------------------------------------------
`default_nettype none

module hit_sqr #(
	parameter int IW = hit_pkg::EW
) (
	input wire logic clk,
	input wire logic signed [IW-1:0] a,
	output logic [2*IW-1:0] sq
);

	localparam int K = (IW + 2) / 3;
	localparam int MW = 3 * K;
	localparam int SW = 6 * K;

	logic [IW-1:0] mag_s5;
	logic [MW-1:0] m_pad;
	logic [K-1:0] c0;
	logic [K-1:0] c1;
	logic [K-1:0] c2;
	logic [2*K-1:0] p00_s6;
	logic [2*K-1:0] p11_s6;
	logic [2*K-1:0] p22_s6;
	logic [2*K-1:0] p01_s6;
	logic [2*K-1:0] p02_s6;
	logic [2*K-1:0] p12_s6;
	logic [SW-1:0] sum;
	logic [2*IW-1:0] sq_s7;

	always_ff @(posedge clk) begin
		mag_s5 <= a[IW-1] ? unsigned'(-a) : unsigned'(a);
	end

	assign m_pad = MW'(mag_s5);
	assign c0 = m_pad[K-1:0];
	assign c1 = m_pad[2*K-1:K];
	assign c2 = m_pad[3*K-1:2*K];

	always_ff @(posedge clk) begin
		p00_s6 <= c0 * c0;
		p11_s6 <= c1 * c1;
		p22_s6 <= c2 * c2;
		p01_s6 <= c0 * c1;
		p02_s6 <= c0 * c2;
		p12_s6 <= c1 * c2;
	end

	assign sum = {p22_s6, p11_s6, p00_s6}
		+ (SW'(p01_s6) << (K + 1))
		+ (SW'(p02_s6) << (2 * K + 1))
		+ (SW'(p12_s6) << (3 * K + 1));

	always_ff @(posedge clk) begin
		sq_s7 <= sum[2*IW-1:0];
	end

	assign sq = sq_s7;

endmodule

`default_nettype wire

// ===== hdl/homography_inlier_test.sv =====
// ----------------------------------------------------------------------------
// Homography inlier test
// Reprojection inlier check of point matches against a configured homography.
// ----------------------------------------------------------------------------
// The block takes one request in every clock cycle and never raises busy.
// Each request produces exactly one result, shown for a single cycle with
// result_valid high; results come out in request order and cannot be held
// back. The pipeline depth is set by the split of the wide error squares into
// partial products: two stages of projection, two of error forming, three of
// squaring and two of summing and comparing.
// Configuration writes are always accepted (cfg_ready stays high) and must
// be made while no request is in flight.
`default_nettype none

module homography_inlier_test (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire hit_pkg::hit_req_t req,
	output logic result_valid,
	output hit_pkg::hit_result_t result,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [hit_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [hit_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int EW = hit_pkg::EW;
	localparam int TW = hit_pkg::TW;
	localparam int LW = hit_pkg::LW;
	localparam int UW = hit_pkg::UW;
	localparam int CW = hit_pkg::COORD_WIDTH;
	localparam int DEPTH = hit_pkg::PIPE_DEPTH;
	localparam int DEG_DEPTH = hit_pkg::DEG_DEPTH;

	logic [hit_pkg::CFG_DATA_W-1:0] row0_ab_q;
	logic [hit_pkg::CFG_DATA_W-1:0] h02_h10_q;
	logic [hit_pkg::CFG_DATA_W-1:0] h11_h12_q;
	logic [hit_pkg::CFG_DATA_W-1:0] h20_h21_q;
	logic [hit_pkg::COEF_W-1:0] h22_q;
	logic [hit_pkg::TOL_W-1:0] tol_q;
	hit_pkg::hit_coef_t coef;

	logic req_accept;
	logic [DEPTH-1:0] vld_q;
	logic [DEPTH-1:0][hit_pkg::IDX_W-1:0] idx_q;
	logic [DEG_DEPTH-1:0] deg_q;

	logic signed [UW-1:0] u_s2;
	logic signed [UW-1:0] v_s2;
	logic signed [UW-1:0] w_s2;
	logic signed [CW-1:0] dx_s2;
	logic signed [CW-1:0] dy_s2;
	logic signed [EW-1:0] ex_s4;
	logic signed [EW-1:0] ey_s4;
	logic signed [TW-1:0] t_s4;
	logic [2*EW-1:0] sqx_s7;
	logic [2*EW-1:0] sqy_s7;
	logic [2*TW-1:0] sqt_s7;
	logic [LW-1:0] lhs_s8;
	logic [2*TW-1:0] rhs_s8;
	logic inl_s9;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;
	assign req_accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row0_ab_q <= hit_pkg::RST_ROW0_AB;
			h02_h10_q <= hit_pkg::RST_H02_H10;
			h11_h12_q <= hit_pkg::RST_H11_H12;
			h20_h21_q <= hit_pkg::RST_H20_H21;
			h22_q <= hit_pkg::RST_H22;
			tol_q <= hit_pkg::RST_TOL;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				hit_pkg::REG_ROW0_AB: row0_ab_q <= cfg_data;
				hit_pkg::REG_H02_H10: h02_h10_q <= cfg_data;
				hit_pkg::REG_H11_H12: h11_h12_q <= cfg_data;
				hit_pkg::REG_H20_H21: h20_h21_q <= cfg_data;
				hit_pkg::REG_H22: h22_q <= cfg_data[hit_pkg::COEF_W-1:0];
				hit_pkg::REG_TOL: tol_q <= cfg_data[hit_pkg::TOL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		coef.h00 = $signed(row0_ab_q[63:32]);
		coef.h01 = $signed(row0_ab_q[31:0]);
		coef.h02 = $signed(h02_h10_q[63:32]);
		coef.h10 = $signed(h02_h10_q[31:0]);
		coef.h11 = $signed(h11_h12_q[63:32]);
		coef.h12 = $signed(h11_h12_q[31:0]);
		coef.h20 = $signed(h20_h21_q[63:32]);
		coef.h21 = $signed(h20_h21_q[31:0]);
		coef.h22 = $signed(h22_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[DEPTH-2:0], req_accept};
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= {idx_q[DEPTH-2:0], req.match_index};
		deg_q <= {deg_q[DEG_DEPTH-2:0], (w_s2 == '0)};
	end

	hit_proj u_proj (
		.clk(clk),
		.coef(coef),
		.src_x(req.src_x),
		.src_y(req.src_y),
		.dst_x(req.dst_x),
		.dst_y(req.dst_y),
		.u_s2(u_s2),
		.v_s2(v_s2),
		.w_s2(w_s2),
		.dx_s2(dx_s2),
		.dy_s2(dy_s2)
	);

	hit_err u_err (
		.clk(clk),
		.tol(tol_q),
		.u_s2(u_s2),
		.v_s2(v_s2),
		.w_s2(w_s2),
		.dx_s2(dx_s2),
		.dy_s2(dy_s2),
		.ex_s4(ex_s4),
		.ey_s4(ey_s4),
		.t_s4(t_s4)
	);

	hit_sqr #(.IW(EW)) u_sqr_x (
		.clk(clk),
		.a(ex_s4),
		.sq(sqx_s7)
	);

	hit_sqr #(.IW(EW)) u_sqr_y (
		.clk(clk),
		.a(ey_s4),
		.sq(sqy_s7)
	);

	hit_sqr #(.IW(TW)) u_sqr_t (
		.clk(clk),
		.a(t_s4),
		.sq(sqt_s7)
	);

	always_ff @(posedge clk) begin
		lhs_s8 <= LW'(sqx_s7) + LW'(sqy_s7);
		rhs_s8 <= sqt_s7;
	end

	always_ff @(posedge clk) begin
		inl_s9 <= !deg_q[DEG_DEPTH-2] && (lhs_s8 < LW'(rhs_s8));
	end

	assign result_valid = vld_q[DEPTH-1];
	assign result.match_index_out = idx_q[DEPTH-1];
	assign result.is_inlier = inl_s9;
	assign result.degenerate = deg_q[DEG_DEPTH-1];

endmodule

`default_nettype wire

// ===== hdl/hit_checker.sv =====
// ----------------------------------------------------------------------------
// Homography inlier test checker
// Port-level assertions on request to result ordering and result flags.
// ----------------------------------------------------------------------------
`default_nettype none

`include "homography_inlier_test_macros.svh"

module hit_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire hit_pkg::hit_req_t req,
	input wire logic result_valid,
	input wire hit_pkg::hit_result_t result
);

	localparam int LAT = hit_pkg::PIPE_DEPTH;

	`HIT_ASSERT_IMP(a_result_has_request, clk, arst_n, result_valid, $past(start && !busy, LAT), "result without a matching request")
	`HIT_ASSERT_IMP(a_request_gets_result, clk, arst_n, start && !busy, ##(LAT) result_valid, "request produced no result")
	`HIT_ASSERT_IMP(a_index_kept, clk, arst_n, result_valid, result.match_index_out == $past(req.match_index, LAT), "result index differs from request index")
	`HIT_ASSERT_NEVER(a_degenerate_not_inlier, clk, arst_n, result_valid && result.degenerate && result.is_inlier, "degenerate match flagged as inlier")

endmodule

bind homography_inlier_test hit_checker u_hit_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.req(req),
	.result_valid(result_valid),
	.result(result)
);

`default_nettype wire

// ===== bench/homography_inlier_test_tb.sv =====
// ----------------------------------------------------------------------------
// Homography inlier test bench
// Streams point matches into the inlier check under several homographies and
// tolerances and compares every result with an exact wide-integer predictor.
// The run begins with directed matches: extreme coordinates, distances on the
// tolerance boundary, zero tolerance and a zero denominator. Random matches
// follow, most of them aimed near the projected point and the rest noise.
// ----------------------------------------------------------------------------
`default_nettype none

module homography_inlier_test_tb;

	typedef logic signed [223:0] wide_t;

	typedef struct packed {
		logic [hit_pkg::CFG_DATA_W-1:0] row0_ab;
		logic [hit_pkg::CFG_DATA_W-1:0] h02_h10;
		logic [hit_pkg::CFG_DATA_W-1:0] h11_h12;
		logic [hit_pkg::CFG_DATA_W-1:0] h20_h21;
		logic [hit_pkg::COEF_W-1:0] h22;
		logic [hit_pkg::TOL_W-1:0] tol;
	} homog_cfg_t;

	typedef enum logic [1:0] {STEP_MATCH, STEP_WRITE, STEP_DRAIN} step_kind_t;

	typedef struct {
		step_kind_t kind;
		hit_pkg::hit_req_t req;
		logic [hit_pkg::CFG_IDX_W-1:0] reg_idx;
		logic [hit_pkg::CFG_DATA_W-1:0] reg_data;
		int gap_pct;
	} stim_step_t;

	localparam logic [hit_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [hit_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
	localparam homog_cfg_t RESET_CFG = {hit_pkg::RST_ROW0_AB, hit_pkg::RST_H02_H10,
		hit_pkg::RST_H11_H12, hit_pkg::RST_H20_H21, hit_pkg::RST_H22, hit_pkg::RST_TOL};
	localparam logic [hit_pkg::COEF_W-1:0] ONE_Q24 = 32'h0100_0000;
	localparam int COORD_MIN = -(2 ** (hit_pkg::COORD_WIDTH - 1));
	localparam int COORD_MAX = 2 ** (hit_pkg::COORD_WIDTH - 1) - 1;
	localparam int N_RANDOM = 1900;
	localparam int SETTING_LEN = 240;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	hit_pkg::hit_req_t req = '0;
	logic result_valid;
	hit_pkg::hit_result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [hit_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [hit_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	stim_step_t pending_steps[$];
	hit_pkg::hit_result_t expected_verdicts[$];
	homog_cfg_t live_cfg = RESET_CFG;
	homog_cfg_t plan_cfg = RESET_CFG;
	int in_flight = 0;
	int fail_count = 0;

	homography_inlier_test uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.result_valid(result_valid),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic wide_t sx32(logic [hit_pkg::COEF_W-1:0] h);
		return $signed(h);
	endfunction

	function automatic homog_cfg_t apply_reg(homog_cfg_t c,
			logic [hit_pkg::CFG_IDX_W-1:0] idx, logic [hit_pkg::CFG_DATA_W-1:0] data);
		homog_cfg_t n;
		n = c;
		case (idx)
			hit_pkg::REG_ROW0_AB: n.row0_ab = data;
			hit_pkg::REG_H02_H10: n.h02_h10 = data;
			hit_pkg::REG_H11_H12: n.h11_h12 = data;
			hit_pkg::REG_H20_H21: n.h20_h21 = data;
			hit_pkg::REG_H22: n.h22 = data[hit_pkg::COEF_W-1:0];
			hit_pkg::REG_TOL: n.tol = data[hit_pkg::TOL_W-1:0];
			default: n = c;
		endcase
		return n;
	endfunction

	function automatic void project(homog_cfg_t c, hit_pkg::hit_req_t r, output wide_t u,
			output wide_t v, output wide_t w);
		wide_t x, y;
		x = $signed(r.src_x);
		y = $signed(r.src_y);
		u = sx32(c.row0_ab[63:32]) * x + sx32(c.row0_ab[31:0]) * y
			+ (sx32(c.h02_h10[63:32]) <<< hit_pkg::U_SHIFT);
		v = sx32(c.h02_h10[31:0]) * x + sx32(c.h11_h12[63:32]) * y
			+ (sx32(c.h11_h12[31:0]) <<< hit_pkg::U_SHIFT);
		w = sx32(c.h20_h21[63:32]) * x + sx32(c.h20_h21[31:0]) * y
			+ (sx32(c.h22) <<< hit_pkg::W_SHIFT);
	endfunction

	function automatic hit_pkg::hit_result_t judge_match(homog_cfg_t c, hit_pkg::hit_req_t r);
		wide_t u, v, w, dx, dy, ex, ey, tol, tw;
		hit_pkg::hit_result_t verdict;
		project(c, r, u, v, w);
		dx = $signed(r.dst_x);
		dy = $signed(r.dst_y);
		tol = {208'd0, c.tol};
		ex = dx * w - (u <<< hit_pkg::ERR_SHIFT);
		ey = dy * w - (v <<< hit_pkg::ERR_SHIFT);
		tw = tol * w;
		verdict.match_index_out = r.match_index;
		verdict.degenerate = (w == 0);
		verdict.is_inlier = (w != 0) && (ex * ex + ey * ey < tw * tw);
		return verdict;
	endfunction

	// Places the destination within about one and a half tolerances of the
	// projected source point, so that inliers and outliers both occur.
	function automatic hit_pkg::hit_req_t aim_match(homog_cfg_t c, hit_pkg::hit_req_t r);
		wide_t u, v, w, nx, ny;
		int span;
		hit_pkg::hit_req_t a;
		a = r;
		project(c, r, u, v, w);
		if (w != 0) begin
			span = int'(c.tol) * 3 / 2 + 2;
			nx = (u <<< hit_pkg::ERR_SHIFT) / w
				+ wide_t'(int'($urandom_range(2 * span)) - span);
			ny = (v <<< hit_pkg::ERR_SHIFT) / w
				+ wide_t'(int'($urandom_range(2 * span)) - span);
			if (nx >= wide_t'(COORD_MIN) && nx <= wide_t'(COORD_MAX)
					&& ny >= wide_t'(COORD_MIN) && ny <= wide_t'(COORD_MAX)) begin
				a.dst_x = nx[hit_pkg::COORD_WIDTH-1:0];
				a.dst_y = ny[hit_pkg::COORD_WIDTH-1:0];
			end
		end
		return a;
	endfunction

	function automatic logic [hit_pkg::COEF_W-1:0] near(logic [hit_pkg::COEF_W-1:0] center,
			int spread);
		return center + 32'($urandom_range(2 * spread)) - 32'(spread);
	endfunction

	function automatic logic [hit_pkg::COORD_WIDTH-1:0] small_coord();
		return hit_pkg::COORD_WIDTH'(int'($urandom_range(131071)) - 65536);
	endfunction

	function automatic logic [hit_pkg::COORD_WIDTH-1:0] extreme_coord();
		case ($urandom_range(4))
			0: return 24'h800000;
			1: return 24'h7FFFFF;
			2: return 24'h000000;
			3: return 24'hFFFFFF;
			default: return 24'h000001;
		endcase
	endfunction

	function automatic hit_pkg::hit_req_t make_match(logic [hit_pkg::IDX_W-1:0] idx,
			logic [hit_pkg::COORD_WIDTH-1:0] sx, logic [hit_pkg::COORD_WIDTH-1:0] sy,
			logic [hit_pkg::COORD_WIDTH-1:0] dx, logic [hit_pkg::COORD_WIDTH-1:0] dy);
		hit_pkg::hit_req_t r;
		r.match_index = idx;
		r.src_x = sx;
		r.src_y = sy;
		r.dst_x = dx;
		r.dst_y = dy;
		return r;
	endfunction

	function automatic homog_cfg_t setting_for(int k);
		homog_cfg_t c;
		c = RESET_CFG;
		case (k)
			0, 1, 6: begin
				c.row0_ab = {near(ONE_Q24, 1 << 22), near(32'h0, 1 << 21)};
				c.h02_h10 = {near(32'h0, 400 << 12), near(32'h0, 1 << 21)};
				c.h11_h12 = {near(ONE_Q24, 1 << 22), near(32'h0, 400 << 12)};
				if (k == 1) begin
					c.h20_h21 = {near(32'h0, 1 << 12), near(32'h0, 1 << 12)};
				end else begin
					c.h20_h21 = {near(32'h0, 1 << 6), near(32'h0, 1 << 6)};
				end
				c.h22 = near(ONE_Q24, 1 << 20);
				c.tol = (k == 6) ? 16'h0000 : 16'($urandom_range(16'h0600, 16'h0040));
			end
			2: c = {{4{64'h7FFF_FFFF_7FFF_FFFF}}, 32'h7FFF_FFFF, 16'hFFFF};
			3: c = {{4{64'h8000_0000_8000_0000}}, 32'h8000_0000, 16'hFFFF};
			4: c = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, 16'($urandom)};
			5: begin
				c.h20_h21 = {ONE_Q24, 32'hFF00_0000};
				c.h22 = 32'h0;
				c.tol = 16'h0200;
			end
			default: c.tol = 16'h0001;
		endcase
		return c;
	endfunction

	task automatic queue_match(hit_pkg::hit_req_t r, int pct);
		stim_step_t s;
		s.kind = STEP_MATCH;
		s.req = r;
		s.reg_idx = '0;
		s.reg_data = '0;
		s.gap_pct = pct;
		pending_steps = {pending_steps, s};
	endtask

	task automatic queue_write(logic [hit_pkg::CFG_IDX_W-1:0] idx,
			logic [hit_pkg::CFG_DATA_W-1:0] data, int pct);
		stim_step_t s;
		s.kind = STEP_WRITE;
		s.req = '0;
		s.reg_idx = idx;
		s.reg_data = data;
		s.gap_pct = pct;
		pending_steps = {pending_steps, s};
		plan_cfg = apply_reg(plan_cfg, idx, data);
	endtask

	task automatic queue_drain(int pct);
		stim_step_t s;
		s.kind = STEP_DRAIN;
		s.req = '0;
		s.reg_idx = '0;
		s.reg_data = '0;
		s.gap_pct = pct;
		pending_steps = {pending_steps, s};
	endtask

	task automatic load_setting(homog_cfg_t c, int pct);
		queue_write(REG_SPARE_A, {$urandom, $urandom}, pct);
		queue_write(REG_SPARE_B, {$urandom, $urandom}, pct);
		queue_write(hit_pkg::REG_ROW0_AB, c.row0_ab, pct);
		queue_write(hit_pkg::REG_H02_H10, c.h02_h10, pct);
		queue_write(hit_pkg::REG_H11_H12, c.h11_h12, pct);
		queue_write(hit_pkg::REG_H20_H21, c.h20_h21, pct);
		queue_write(hit_pkg::REG_H22, {$urandom, c.h22}, pct);
		queue_write(hit_pkg::REG_TOL, {$urandom, 16'($urandom), c.tol}, pct);
	endtask

	task automatic random_match(int pct);
		hit_pkg::hit_req_t r;
		int roll;
		r.match_index = hit_pkg::IDX_W'($urandom);
		r.src_x = hit_pkg::COORD_WIDTH'($urandom);
		r.src_y = hit_pkg::COORD_WIDTH'($urandom);
		r.dst_x = hit_pkg::COORD_WIDTH'($urandom);
		r.dst_y = hit_pkg::COORD_WIDTH'($urandom);
		roll = $urandom_range(99);
		if (roll < 70) begin
			if ($urandom_range(1) == 0) begin
				r.src_x = small_coord();
				r.src_y = small_coord();
			end
			if (roll < 8) begin
				r.src_y = r.src_x;
			end
			if (roll < 2) begin
				r.src_x = '0;
				r.src_y = '0;
			end
			r = aim_match(plan_cfg, r);
		end else if (roll >= 90) begin
			r.src_x = extreme_coord();
			r.src_y = extreme_coord();
			r.dst_x = extreme_coord();
			r.dst_y = extreme_coord();
		end
		queue_match(r, pct);
	endtask

	always @(posedge clk or negedge arst_n) begin
		stim_step_t head;
		logic next_start, next_cfg;
		hit_pkg::hit_req_t next_req;
		logic [hit_pkg::CFG_IDX_W-1:0] next_idx;
		logic [hit_pkg::CFG_DATA_W-1:0] next_data;
		int flight;
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
			cfg_valid <= 1'b0;
			cfg_index <= '0;
			cfg_data <= '0;
			in_flight <= 0;
		end else begin
			flight = in_flight + int'(start && !busy) - int'(result_valid);
			next_start = start && busy;
			next_cfg = cfg_valid && !cfg_ready;
			next_req = req;
			next_idx = cfg_index;
			next_data = cfg_data;
			if (!next_start && !next_cfg && pending_steps.size() != 0) begin
				head = pending_steps[0];
				if ($urandom_range(99) >= head.gap_pct) begin
					case (head.kind)
						STEP_MATCH: begin
							next_start = 1'b1;
							next_req = head.req;
							pending_steps.delete(0);
						end
						STEP_WRITE: begin
							if (flight <= 0) begin
								next_cfg = 1'b1;
								next_idx = head.reg_idx;
								next_data = head.reg_data;
								pending_steps.delete(0);
							end
						end
						default: begin
							if (flight <= 0) begin
								pending_steps.delete(0);
							end
						end
					endcase
				end
			end
			start <= next_start;
			req <= next_req;
			cfg_valid <= next_cfg;
			cfg_index <= next_idx;
			cfg_data <= next_data;
			in_flight <= flight;
		end
	end

	always @(posedge clk) begin
		hit_pkg::hit_result_t want;
		if (arst_n) begin
			if (result_valid) begin
				if (expected_verdicts.size() == 0) begin
					if (fail_count < 10) begin
						$display("unexpected result: index %0d inlier %0b degenerate %0b",
							result.match_index_out, result.is_inlier, result.degenerate);
					end
					fail_count++;
				end else begin
					want = expected_verdicts.pop_front();
					if (result.match_index_out !== want.match_index_out
							|| result.is_inlier !== want.is_inlier
							|| result.degenerate !== want.degenerate) begin
						if (fail_count < 10) begin
							$display({"mismatch: expected index %0d inlier %0b degenerate %0b,",
								" got index %0d inlier %0b degenerate %0b"},
								want.match_index_out, want.is_inlier, want.degenerate,
								result.match_index_out, result.is_inlier, result.degenerate);
						end
						fail_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				live_cfg = apply_reg(live_cfg, cfg_index, cfg_data);
			end
			if (start && !busy) begin
				expected_verdicts = {expected_verdicts, judge_match(live_cfg, req)};
			end
		end
	end

	initial begin
		#2_400_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int pct;
		int polls;
		queue_match(make_match(24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000), 0);
		queue_match(make_match(24'hFFFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF), 0);
		queue_match(make_match(24'h000001, 24'h800000, 24'h800000, 24'h800000, 24'h800000), 0);
		queue_match(make_match(24'h000002, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000), 0);
		queue_match(make_match(24'h000003, 24'h000000, 24'h000000, 24'h000100, 24'h000000), 0);
		queue_match(make_match(24'h000004, 24'h000000, 24'h000000, 24'h0000FF, 24'h000000), 0);
		queue_match(make_match(24'h000005, 24'h000000, 24'h000000, 24'h000000, 24'hFFFF00), 0);
		queue_match(make_match(24'h000006, 24'h000000, 24'h000000, 24'h000000, 24'hFFFF01), 0);
		queue_match(make_match(24'h000007, 24'h001000, 24'h002000, 24'h0010B5, 24'h0020B5), 0);
		queue_match(make_match(24'h000008, 24'h001000, 24'h002000, 24'h0010B6, 24'h0020B5), 0);
		queue_match(make_match(24'h000009, 24'h123456, 24'hABCDEF, 24'h123456, 24'hABCDEF), 0);
		queue_write(hit_pkg::REG_TOL, 64'h0, 0);
		queue_match(make_match(24'h00000A, 24'h000000, 24'h000000, 24'h000000, 24'h000000), 0);
		queue_match(make_match(24'h00000B, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000), 0);
		queue_write(hit_pkg::REG_TOL, 64'hFFFF, 0);
		queue_match(make_match(24'h00000C, 24'h000000, 24'h000000, 24'h7FFFFF, 24'h000000), 0);
		queue_match(make_match(24'h00000D, 24'h000000, 24'h000000, 24'h00FF00, 24'h000000), 0);
		queue_match(make_match(24'h00000E, 24'h800000, 24'h000000, 24'h800000, 24'h000000), 0);
		queue_write(hit_pkg::REG_H22, 64'h0, 0);
		queue_match(make_match(24'h00000F, 24'h000000, 24'h000000, 24'h000000, 24'h000000), 0);
		queue_match(make_match(24'h000010, 24'h7FFFFF, 24'h800000, 24'h000000, 24'h000000), 0);
		queue_write(hit_pkg::REG_H20_H21, {ONE_Q24, 32'h0}, 0);
		queue_match(make_match(24'h000011, 24'h000000, 24'h000005, 24'h000000, 24'h000000), 0);
		queue_match(make_match(24'h000012, 24'h000100, 24'h000000, 24'h000100, 24'h000000), 0);
		queue_match(make_match(24'h000013, 24'hFFFF00, 24'h7FFFFF, 24'h000100, 24'h000000), 0);
		queue_drain(0);

		for (int i = 0; i < N_RANDOM; i++) begin
			pct = (i < N_RANDOM / 3) ? 10 : ((i < 2 * N_RANDOM / 3) ? 53 : 0);
			if (i % SETTING_LEN == 0) begin
				load_setting(setting_for(i / SETTING_LEN), pct);
			end
			if (i == 100 || $urandom_range(149) == 0) begin
				queue_drain(pct);
			end
			random_match(pct);
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_steps.size() != 0 || start || cfg_valid) begin
			@(negedge clk);
		end
		polls = 0;
		while (expected_verdicts.size() != 0 && polls < 1000) begin
			@(negedge clk);
			polls++;
		end
		repeat (2 * hit_pkg::PIPE_DEPTH) @(negedge clk);
		if (expected_verdicts.size() != 0 && fail_count < 10) begin
			$display("%0d expected results never arrived", expected_verdicts.size());
		end
		if (fail_count == 0 && expected_verdicts.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
